// ----- rtl/grid_max_path_count_top_macros.svh -----
// Assertion macros for the grid max path count block.
`ifndef GRID_MAX_PATH_COUNT_TOP_MACROS_SVH
`define GRID_MAX_PATH_COUNT_TOP_MACROS_SVH

// Same-cycle implication, clocked on clk, quiet while rst_n is low.
`define GMPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, quiet while rst_n is low.
`define GMPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/gmpc_pkg.sv -----
// Shared constants for the grid max path count block.
package gmpc_pkg;

    localparam int SUM_W       = 8;    // best_sum width
    localparam int OUT_COUNT_W = 32;   // path_count port width
    localparam int CFG_W       = 8;    // configuration register width
    localparam int ROW_LIMIT   = 128;  // largest grid height
    localparam int ROW_W       = 7;    // row position width
    localparam int ROWS_W      = 8;    // effective row count width
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    typedef enum logic
    {
        REG_GRID_ROWS = 1'b0,
        REG_GRID_COLS = 1'b1
    } reg_idx_t;

endpackage

// ----- rtl/grid_max_path_count_top.sv -----
// Top level: raster-order grid best path sum and path count over a row store.
//
//   channel   dir   handshake             beat payload
//   cell      in    cell_valid/cell_stall  cell_mark
//   res       out   res_valid/res_stall    best_sum, path_count, last_cell
//   apb       in    psel/penable/pready    paddr, pwdata, prdata
//
// One cell per cycle unless res stalls; results pass compute stage, then result register.
// The row store is one memory read at beat time and written when the result
// leaves the compute stage; a same-column collision (one-column grids) is forwarded.
// No clearing pass after reset: an entry is always written before a read of it is used.
// A stall on res reaches cell_stall when the compute stage and result register are full.

`include "grid_max_path_count_top_macros.svh"

module grid_max_path_count_top #(
    parameter int MAX_COLS   = 128,
    parameter int COUNT_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [gmpc_pkg::PADDR_W-1:0]      paddr,
    input  logic [gmpc_pkg::PDATA_W-1:0]      pwdata,
    output logic [gmpc_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready,
    // cell channel
    input  logic                              cell_valid,
    output logic                              cell_stall,
    input  logic                              cell_mark,
    // result channel
    output logic                              res_valid,
    input  logic                              res_stall,
    output logic [gmpc_pkg::SUM_W-1:0]        best_sum,
    output logic [gmpc_pkg::OUT_COUNT_W-1:0]  path_count,
    output logic                              last_cell
);

    localparam int COL_AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CW     = $clog2(MAX_COLS + 1) + 1;
    localparam int SW     = gmpc_pkg::SUM_W;
    localparam int MW     = SW + COUNT_BITS;

    // ---------------- configuration ----------------
    logic [gmpc_pkg::CFG_W-1:0] grid_rows_reg;
    logic [gmpc_pkg::CFG_W-1:0] grid_cols_reg;
    logic                       cfg_wr;
    gmpc_pkg::reg_idx_t         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = gmpc_pkg::reg_idx_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        case (cfg_idx)
            gmpc_pkg::REG_GRID_ROWS: prdata = gmpc_pkg::PDATA_W'(grid_rows_reg);
            gmpc_pkg::REG_GRID_COLS: prdata = gmpc_pkg::PDATA_W'(grid_cols_reg);
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= gmpc_pkg::CFG_W'(1);
            grid_cols_reg <= gmpc_pkg::CFG_W'(1);
        end
        else if (cfg_wr)
        begin
            if (cfg_idx == gmpc_pkg::REG_GRID_ROWS)
                grid_rows_reg <= pwdata[gmpc_pkg::CFG_W-1:0];
            else
                grid_cols_reg <= pwdata[gmpc_pkg::CFG_W-1:0];
        end
    end

    // effective grid size, zero taken as one, clamped to the limits
    logic [gmpc_pkg::ROWS_W-1:0] rows_eff;
    logic [CW-1:0]               cols_eff;

    always_comb
    begin
        if (grid_rows_reg == '0)
            rows_eff = gmpc_pkg::ROWS_W'(1);
        else if (16'(grid_rows_reg) > 16'(gmpc_pkg::ROW_LIMIT))
            rows_eff = gmpc_pkg::ROWS_W'(gmpc_pkg::ROW_LIMIT);
        else
            rows_eff = gmpc_pkg::ROWS_W'(grid_rows_reg);

        if (grid_cols_reg == '0)
            cols_eff = CW'(1);
        else if (16'(grid_cols_reg) > 16'(MAX_COLS))
            cols_eff = CW'(MAX_COLS);
        else
            cols_eff = CW'(grid_cols_reg);
    end

    // ---------------- position and beat front ----------------
    logic [gmpc_pkg::ROW_W-1:0] row_reg;
    logic [CW-1:0]              col_reg;
    logic [gmpc_pkg::ROW_W-1:0] r_cur;
    logic [CW-1:0]              c_cur;
    logic                       row_wrap;
    logic                       col_wrap;
    logic                       cell_acc;
    logic [COL_AW-1:0]          rd_addr;

    // compute stage
    logic                       a_valid_reg;
    logic                       a_mark_reg;
    logic                       a_top_reg;
    logic                       a_left_edge_reg;
    logic                       a_last_reg;
    logic                       a_fwd_reg;
    logic [COL_AW-1:0]          a_col_reg;
    logic                       a_adv;

    // result register
    logic                       res_valid_reg;
    logic [SW-1:0]              best_sum_reg;
    logic [COUNT_BITS-1:0]      path_count_reg;
    logic                       last_cell_reg;

    assign a_adv      = a_valid_reg && (!res_valid_reg || !res_stall);
    assign cell_stall = a_valid_reg && !a_adv;
    assign cell_acc   = cell_valid && !cell_stall;

    always_comb
    begin
        r_cur    = ({1'b0, row_reg} >= rows_eff) ? '0 : row_reg;
        c_cur    = (col_reg >= cols_eff) ? '0 : col_reg;
        rd_addr  = c_cur[COL_AW-1:0];
        col_wrap = (c_cur + CW'(1)) >= cols_eff;
        row_wrap = ({1'b0, r_cur} + gmpc_pkg::ROWS_W'(1)) >= rows_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (cfg_wr)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (cell_acc)
        begin
            if (col_wrap)
            begin
                col_reg <= '0;
                row_reg <= row_wrap ? '0 : r_cur + gmpc_pkg::ROW_W'(1);
            end
            else
            begin
                col_reg <= c_cur + CW'(1);
                row_reg <= r_cur;
            end
        end
    end

    // ---------------- row store ----------------
    logic [MW-1:0] row_mem [MAX_COLS];
    logic [MW-1:0] mem_rd_reg;
    logic          mem_we;
    logic [SW-1:0]         res_sum;
    logic [COUNT_BITS-1:0] res_cnt;

    assign mem_we = a_adv;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            row_mem[a_col_reg] <= {res_sum, res_cnt};
        if (cell_acc)
            mem_rd_reg <= row_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (cell_acc)
            a_valid_reg <= 1'b1;
        else if (a_adv)
            a_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cell_acc)
        begin
            a_mark_reg      <= cell_mark;
            a_top_reg       <= (r_cur == '0);
            a_left_edge_reg <= (c_cur == '0);
            a_last_reg      <= ({1'b0, r_cur} == rows_eff - gmpc_pkg::ROWS_W'(1))
                               && (c_cur == cols_eff - CW'(1));
            a_col_reg       <= rd_addr;
            // the entry being read is written this very cycle: take it from the left cell
            a_fwd_reg       <= mem_we && (a_col_reg == rd_addr);
        end
    end

    // ---------------- compute ----------------
    logic [SW-1:0]         left_sum_reg;
    logic [COUNT_BITS-1:0] left_count_reg;
    logic [SW-1:0]         up_sum;
    logic [COUNT_BITS-1:0] up_cnt;
    logic [SW-1:0]         sel_sum;
    logic [COUNT_BITS-1:0] sel_cnt;
    logic [COUNT_BITS:0]   cnt_sum;

    always_comb
    begin
        up_sum  = a_fwd_reg ? left_sum_reg   : mem_rd_reg[MW-1:COUNT_BITS];
        up_cnt  = a_fwd_reg ? left_count_reg : mem_rd_reg[COUNT_BITS-1:0];
        cnt_sum = {1'b0, up_cnt} + {1'b0, left_count_reg};

        if (a_top_reg && a_left_edge_reg)
        begin
            sel_sum = '0;
            sel_cnt = COUNT_BITS'(1);
        end
        else if (a_top_reg)
        begin
            sel_sum = left_sum_reg;
            sel_cnt = left_count_reg;
        end
        else if (a_left_edge_reg)
        begin
            sel_sum = up_sum;
            sel_cnt = up_cnt;
        end
        else if (up_sum > left_sum_reg)
        begin
            sel_sum = up_sum;
            sel_cnt = up_cnt;
        end
        else if (up_sum < left_sum_reg)
        begin
            sel_sum = left_sum_reg;
            sel_cnt = left_count_reg;
        end
        else
        begin
            // tie: counts add, saturating on carry
            sel_sum = up_sum;
            sel_cnt = cnt_sum[COUNT_BITS] ? '1 : cnt_sum[COUNT_BITS-1:0];
        end

        res_sum = (sel_sum == '1) ? sel_sum : sel_sum + SW'(a_mark_reg);
        res_cnt = sel_cnt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_sum_reg   <= '0;
            left_count_reg <= '0;
        end
        else if (a_adv)
        begin
            left_sum_reg   <= res_sum;
            left_count_reg <= res_cnt;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (a_adv)
            res_valid_reg <= 1'b1;
        else if (!res_stall)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (a_adv)
        begin
            best_sum_reg   <= res_sum;
            path_count_reg <= res_cnt;
            last_cell_reg  <= a_last_reg;
        end
    end

    logic [63:0] count_wide;

    assign count_wide = 64'(path_count_reg);
    assign res_valid  = res_valid_reg;
    assign best_sum   = best_sum_reg;
    assign path_count = count_wide[gmpc_pkg::OUT_COUNT_W-1:0];
    assign last_cell  = last_cell_reg;

    // ---------------- assertions ----------------
    `GMPC_ASSERT_NOW(a_stall_needs_full, cell_stall, a_valid_reg,
        "cell_stall raised with the compute stage empty")
    `GMPC_ASSERT_NOW(a_we_needs_item, mem_we, a_valid_reg && (!res_valid_reg || !res_stall),
        "row store written without a result moving on")
    `GMPC_ASSERT_NOW(a_fwd_one_col, a_valid_reg && a_fwd_reg, cols_eff == CW'(1),
        "same-column forward on a grid wider than one column")
    `GMPC_ASSERT_NOW(a_corner_count, a_valid_reg && a_top_reg && a_left_edge_reg,
        res_cnt == COUNT_BITS'(1), "top-left cell count is not one")
    `GMPC_ASSERT_NEXT(a_adv_fills_res, a_adv, res_valid_reg,
        "result register empty after the compute stage moved on")

endmodule

// ----- test/grid_max_path_count_top_test.sv -----
// Self-checking testbench for grid_max_path_count_top: random grids, stalls and APB setup.
module grid_max_path_count_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COL_LIMIT   = 128;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 650;

    typedef struct packed {
        logic [gmpc_pkg::SUM_W-1:0]       sum;
        logic [gmpc_pkg::OUT_COUNT_W-1:0] count;
        logic                             at_end;
    } path_result_t;

    // Tracks the grid walk and holds the best-path results still to come out.
    class grid_path_scoreboard;
        logic [gmpc_pkg::CFG_W-1:0]       rows_cfg;
        logic [gmpc_pkg::CFG_W-1:0]       cols_cfg;
        logic [gmpc_pkg::SUM_W-1:0]       above_sums [COL_LIMIT];
        logic [gmpc_pkg::OUT_COUNT_W-1:0] above_counts [COL_LIMIT];
        logic [gmpc_pkg::SUM_W-1:0]       left_sum;
        logic [gmpc_pkg::OUT_COUNT_W-1:0] left_count;
        int                               row_pos;
        int                               col_pos;
        path_result_t                     awaited_paths [$];
        int                               errors;

        function new();
            rows_cfg   = gmpc_pkg::CFG_W'(1);
            cols_cfg   = gmpc_pkg::CFG_W'(1);
            left_sum   = '0;
            left_count = '0;
            row_pos    = 0;
            col_pos    = 0;
            errors     = 0;
        endfunction

        function int clip_dim(logic [gmpc_pkg::CFG_W-1:0] v, int top);
            if (v == 0)
                return 1;
            if (int'(v) > top)
                return top;
            return int'(v);
        endfunction

        function logic [gmpc_pkg::OUT_COUNT_W-1:0] sat_add(
            logic [gmpc_pkg::OUT_COUNT_W-1:0] a,
            logic [gmpc_pkg::OUT_COUNT_W-1:0] b);
            logic [gmpc_pkg::OUT_COUNT_W:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[gmpc_pkg::OUT_COUNT_W] ? '1 : s[gmpc_pkg::OUT_COUNT_W-1:0];
        endfunction

        function void set_reg(gmpc_pkg::reg_idx_t idx, logic [gmpc_pkg::PDATA_W-1:0] val);
            if (idx == gmpc_pkg::REG_GRID_ROWS)
                rows_cfg = val[gmpc_pkg::CFG_W-1:0];
            else
                cols_cfg = val[gmpc_pkg::CFG_W-1:0];
            row_pos = 0;
            col_pos = 0;
        endfunction

        function void check_reg(gmpc_pkg::reg_idx_t idx, logic [gmpc_pkg::PDATA_W-1:0] got);
            logic [gmpc_pkg::PDATA_W-1:0] want;
            want = gmpc_pkg::PDATA_W'(idx == gmpc_pkg::REG_GRID_ROWS ? rows_cfg : cols_cfg);
            if (got !== want)
            begin
                $display("%0t: prdata reg %s expected %0d got %0d", $time, idx.name(), want, got);
                errors++;
            end
        endfunction

        function void add_cell(logic mark);
            int                               rows;
            int                               cols;
            int                               r;
            int                               c;
            logic [gmpc_pkg::SUM_W:0]         best;
            logic [gmpc_pkg::OUT_COUNT_W-1:0] cnt;
            path_result_t                     res;
            rows = clip_dim(rows_cfg, gmpc_pkg::ROW_LIMIT);
            cols = clip_dim(cols_cfg, COL_LIMIT);
            r = (row_pos >= rows) ? 0 : row_pos;
            c = (col_pos >= cols) ? 0 : col_pos;
            if (r == 0 && c == 0)
            begin
                best = '0;
                cnt  = gmpc_pkg::OUT_COUNT_W'(1);
            end
            else if (r == 0)
            begin
                best = {1'b0, left_sum};
                cnt  = left_count;
            end
            else if (c == 0)
            begin
                best = {1'b0, above_sums[0]};
                cnt  = above_counts[0];
            end
            else if (above_sums[c] > left_sum)
            begin
                best = {1'b0, above_sums[c]};
                cnt  = above_counts[c];
            end
            else if (above_sums[c] < left_sum)
            begin
                best = {1'b0, left_sum};
                cnt  = left_count;
            end
            else
            begin
                // tie: both neighbours reach the same best, so their paths add up
                best = {1'b0, above_sums[c]};
                cnt  = sat_add(above_counts[c], left_count);
            end
            best = best + mark;
            if (best[gmpc_pkg::SUM_W])
                best = {1'b0, {gmpc_pkg::SUM_W{1'b1}}};
            above_sums[c]   = best[gmpc_pkg::SUM_W-1:0];
            above_counts[c] = cnt;
            left_sum        = best[gmpc_pkg::SUM_W-1:0];
            left_count      = cnt;
            res.sum    = best[gmpc_pkg::SUM_W-1:0];
            res.count  = cnt;
            res.at_end = (r == rows - 1) && (c == cols - 1);
            awaited_paths.push_back(res);
            if (c + 1 >= cols)
            begin
                col_pos = 0;
                row_pos = (r + 1 >= rows) ? 0 : r + 1;
            end
            else
            begin
                col_pos = c + 1;
                row_pos = r;
            end
        endfunction

        function void check_result(logic [gmpc_pkg::SUM_W-1:0] sum,
                                   logic [gmpc_pkg::OUT_COUNT_W-1:0] count,
                                   logic at_end);
            path_result_t want;
            if (awaited_paths.size() == 0)
            begin
                $display("%0t: result beat with none expected: sum %0d count %0d last %0b",
                         $time, sum, count, at_end);
                errors++;
                return;
            end
            want = awaited_paths.pop_front();
            if (sum !== want.sum)
            begin
                $display("%0t: best_sum expected %0d got %0d", $time, want.sum, sum);
                errors++;
            end
            if (count !== want.count)
            begin
                $display("%0t: path_count expected %0d got %0d", $time, want.count, count);
                errors++;
            end
            if (at_end !== want.at_end)
            begin
                $display("%0t: last_cell expected %0b got %0b", $time, want.at_end, at_end);
                errors++;
            end
        endfunction

        function int pending();
            return awaited_paths.size();
        endfunction
    endclass

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             psel = 1'b0;
    logic                             penable = 1'b0;
    logic                             pwrite = 1'b0;
    logic [gmpc_pkg::PADDR_W-1:0]     paddr = '0;
    logic [gmpc_pkg::PDATA_W-1:0]     pwdata = '0;
    logic [gmpc_pkg::PDATA_W-1:0]     prdata;
    logic                             pready;
    logic                             cell_valid = 1'b0;
    logic                             cell_stall;
    logic                             cell_mark = 1'b0;
    logic                             res_valid;
    logic                             res_stall = 1'b0;
    logic [gmpc_pkg::SUM_W-1:0]       best_sum;
    logic [gmpc_pkg::OUT_COUNT_W-1:0] path_count;
    logic                             last_cell;

    grid_path_scoreboard sb = new();
    bit                  calm = 1'b1;
    int                  cycles = 0;
    int                  sent = 0;

    grid_max_path_count_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .cell_valid (cell_valid),
        .cell_stall (cell_stall),
        .cell_mark  (cell_mark),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .best_sum   (best_sum),
        .path_count (path_count),
        .last_cell  (last_cell)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(negedge clk)
        res_stall <= !calm && ($urandom_range(99) < 20);

    always @(posedge clk)
        if (rst_n && res_valid && !res_stall)
            sb.check_result(best_sum, path_count, last_cell);

    function bit take_gap();
        return !calm && ($urandom_range(99) < 20);
    endfunction

    task automatic send_mark(logic mark);
        @(negedge clk);
        while (take_gap())
        begin
            cell_valid <= 1'b0;
            @(negedge clk);
        end
        cell_valid <= 1'b1;
        cell_mark  <= mark;
        @(posedge clk);
        while (cell_stall)
            @(posedge clk);
        sb.add_cell(mark);
        sent++;
    endtask

    // drop valid, then let every result out before touching the registers
    task automatic drain();
        @(negedge clk);
        cell_valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic reg_write(gmpc_pkg::reg_idx_t idx, logic [gmpc_pkg::PDATA_W-1:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_reg(idx, val);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic reg_read(gmpc_pkg::reg_idx_t idx);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.check_reg(idx, prdata);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_grid(logic [gmpc_pkg::CFG_W-1:0] rows,
                            logic [gmpc_pkg::CFG_W-1:0] cols);
        logic [gmpc_pkg::PDATA_W-1:0] junk;
        // upper data bits are don't-care; throw some noise at them now and then
        junk = '0;
        if ($urandom_range(3) == 0)
            junk = {24'($urandom()), 8'h00};
        if ($urandom_range(1))
        begin
            reg_write(gmpc_pkg::REG_GRID_ROWS, junk | gmpc_pkg::PDATA_W'(rows));
            reg_write(gmpc_pkg::REG_GRID_COLS, junk | gmpc_pkg::PDATA_W'(cols));
        end
        else
        begin
            reg_write(gmpc_pkg::REG_GRID_COLS, junk | gmpc_pkg::PDATA_W'(cols));
            reg_write(gmpc_pkg::REG_GRID_ROWS, junk | gmpc_pkg::PDATA_W'(rows));
        end
        if ($urandom_range(2) == 0)
        begin
            reg_read(gmpc_pkg::REG_GRID_ROWS);
            reg_read(gmpc_pkg::REG_GRID_COLS);
        end
    endtask

    task automatic send_pattern(logic [31:0] bits, int n);
        for (int i = 0; i < n; i++)
            send_mark(bits[i]);
    endtask

    initial
    begin
        int                         phase;
        int                         rows_eff;
        int                         cols_eff;
        int                         n;
        int                         density;
        logic [gmpc_pkg::CFG_W-1:0] rows;
        logic [gmpc_pkg::CFG_W-1:0] cols;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset state is a 1x1 grid
        reg_read(gmpc_pkg::REG_GRID_ROWS);
        reg_read(gmpc_pkg::REG_GRID_COLS);
        send_pattern(32'b10, 2);
        drain();

        // zero size behaves as 1x1
        set_grid(8'd0, 8'd0);
        send_pattern(32'b01, 2);
        drain();

        // 2x3: all-zero grid gives ties, then a marked grid with a tie and left winning
        set_grid(8'd2, 8'd3);
        send_pattern(32'b110001_000000, 12);
        drain();

        // 3x2 broken off mid-grid, then rewriting the same value restarts the walk
        set_grid(8'd3, 8'd2);
        send_pattern(32'b101, 3);
        drain();
        reg_write(gmpc_pkg::REG_GRID_COLS, 32'd2);
        send_pattern(32'b011, 3);
        drain();

        // oversize values clip to the largest grid
        set_grid(8'd255, 8'd200);
        send_pattern(32'b110, 3);
        drain();
        set_grid(8'd129, 8'd1);
        send_pattern(32'b01, 2);
        drain();

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            calm    = (phase == 1) || ($urandom_range(4) == 0);
            density = 50;
            case (phase == 0 ? 0 : $urandom_range(1, 8))
                0:
                begin
                    // all-zero 19x19: path counts pass the top and saturate
                    rows    = gmpc_pkg::CFG_W'(19);
                    cols    = gmpc_pkg::CFG_W'(19);
                    density = 0;
                end
                1:
                begin
                    rows = gmpc_pkg::CFG_W'($urandom_range(1) ? 128 : $urandom_range(129, 255));
                    cols = gmpc_pkg::CFG_W'($urandom_range(1, 2));
                end
                2:
                begin
                    rows = gmpc_pkg::CFG_W'($urandom_range(1, 2));
                    cols = gmpc_pkg::CFG_W'($urandom_range(1) ? 128 : $urandom_range(129, 255));
                end
                default:
                begin
                    rows = gmpc_pkg::CFG_W'($urandom_range(0, 8));
                    cols = gmpc_pkg::CFG_W'($urandom_range(0, 8));
                    case ($urandom_range(4))
                        0: density = 0;
                        1: density = 10;
                        2: density = 90;
                        3: density = 100;
                        default: density = 50;
                    endcase
                end
            endcase
            set_grid(rows, cols);
            rows_eff = sb.clip_dim(rows, gmpc_pkg::ROW_LIMIT);
            cols_eff = sb.clip_dim(cols, COL_LIMIT);
            n = rows_eff * cols_eff;
            if (n <= 64)
                n = n * $urandom_range(1, 3);
            // now and then stop part way through a grid
            if ($urandom_range(3) == 0)
                n = n + $urandom_range(0, rows_eff * cols_eff - 1);
            if (n > RANDOM_ITEMS - sent)
                n = RANDOM_ITEMS - sent;
            for (int i = 0; i < n; i++)
                send_mark($urandom_range(99) < density);
            drain();
            phase++;
        end

        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
